// ===== sv/m3i_pkg.sv =====
// Shared constants for the 3x3 adjugate matrix inverse.
package m3i_pkg;

  parameter int DATA_WIDTH_DEF = 32;
  parameter int FRAC_BITS_DEF  = 16;

  parameter int MID_DEPTH = 2;
  parameter int OUT_DEPTH = 2;

  parameter int REG_THRESHOLD = 0;

  // cofactor i = a[p]*a[q] - a[r]*a[s], entries in row-major order
  parameter logic [3:0] COF_IDX [9][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

endpackage

// ===== sv/mat3_inverse_adjugate.sv =====
// Top level of the 3x3 fixed-point matrix inverse by adjugate.
//
// Input channel: drive a00..a22 with push; a beat is taken when push is high
// and full is low. Result channel: b00..b22, det_value and singular show the
// oldest result while empty is low; pop takes it.
// The APB port holds singular_threshold at byte address 0 (reset value 1).
// A front pipeline of eight stages forms cofactors, determinant and the
// singular flag and feeds a two-entry queue. A back pipeline of W+3 stages
// runs nine restoring dividers, one quotient bit per stage, and feeds a
// two-entry output queue.
// One matrix is taken every cycle while results are drained.
// When pop stays low the back pipeline holds, then the middle queue fills,
// the front pipeline holds and full rises. No beat is lost.
// Reset empties both pipelines and both queues and sets the threshold to 1.
module mat3_inverse_adjugate #(
  parameter int DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF,
  localparam int PDW = (DATA_WIDTH - 1 > 32) ? 64 : 32,
  localparam int PAW = (PDW == 64) ? 4 : 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic signed [DATA_WIDTH-1:0] a00,
  input  logic signed [DATA_WIDTH-1:0] a01,
  input  logic signed [DATA_WIDTH-1:0] a02,
  input  logic signed [DATA_WIDTH-1:0] a10,
  input  logic signed [DATA_WIDTH-1:0] a11,
  input  logic signed [DATA_WIDTH-1:0] a12,
  input  logic signed [DATA_WIDTH-1:0] a20,
  input  logic signed [DATA_WIDTH-1:0] a21,
  input  logic signed [DATA_WIDTH-1:0] a22,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [DATA_WIDTH-1:0] b00,
  output logic signed [DATA_WIDTH-1:0] b01,
  output logic signed [DATA_WIDTH-1:0] b02,
  output logic signed [DATA_WIDTH-1:0] b10,
  output logic signed [DATA_WIDTH-1:0] b11,
  output logic signed [DATA_WIDTH-1:0] b12,
  output logic signed [DATA_WIDTH-1:0] b20,
  output logic signed [DATA_WIDTH-1:0] b21,
  output logic signed [DATA_WIDTH-1:0] b22,
  output logic signed [DATA_WIDTH-1:0] det_value,
  output logic                         singular,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [PAW-1:0]               paddr,
  input  logic [PDW-1:0]               pwdata,
  output logic [PDW-1:0]               prdata,
  output logic                         pready
);

  localparam int W = DATA_WIDTH;
  localparam int CW = 2 * W + 1;
  localparam int DTW = 3 * W + 3;
  localparam int MIDW = 2 + W + DTW + 9 * CW;
  localparam int OUTW = 1 + W + 9 * W;

  logic [W-2:0]      thr;
  logic              reg_hit;
  logic [9*W-1:0]    in_data;
  logic              mid_push;
  logic              mid_full;
  logic              mid_pop;
  logic              mid_empty;
  logic [MIDW-1:0]   mid_wdata;
  logic [MIDW-1:0]   mid_rdata;
  logic              out_push;
  logic              out_full;
  logic [OUTW-1:0]   out_wdata;
  logic [OUTW-1:0]   out_rdata;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PAW-1:PAW-1] == 1'(m3i_pkg::REG_THRESHOLD));

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= (W - 1)'(1);
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      thr <= pwdata[W-2:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = PDW'(thr);
    end
  end

  assign full    = mid_full;
  assign in_data = {a22, a21, a20, a12, a11, a10, a02, a01, a00};

  m3i_front #(.W(W), .F(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_push  (push && !full),
    .in_data  (in_data),
    .thr      (thr),
    .mid_full (mid_full),
    .mid_push (mid_push),
    .mid_data (mid_wdata)
  );

  m3i_queue #(.WIDTH(MIDW), .DEPTH(m3i_pkg::MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  m3i_back #(.W(W), .F(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_empty (mid_empty),
    .mid_data  (mid_rdata),
    .mid_pop   (mid_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_data  (out_wdata)
  );

  m3i_queue #(.WIDTH(OUTW), .DEPTH(m3i_pkg::OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_wdata),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign b00       = out_rdata[0*W +: W];
  assign b01       = out_rdata[1*W +: W];
  assign b02       = out_rdata[2*W +: W];
  assign b10       = out_rdata[3*W +: W];
  assign b11       = out_rdata[4*W +: W];
  assign b12       = out_rdata[5*W +: W];
  assign b20       = out_rdata[6*W +: W];
  assign b21       = out_rdata[7*W +: W];
  assign b22       = out_rdata[8*W +: W];
  assign det_value = out_rdata[9*W +: W];
  assign singular  = out_rdata[OUTW-1];

endmodule

// ===== sv/m3i_queue.sv =====
// Small first-in first-out queue in flip-flops with show-ahead read.
module m3i_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt == CNTW'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= CNTW'(DEPTH))
    else $error("queue count out of range");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && !push && cnt == CNTW'(1)) |=> empty)
    else $error("queue not empty after last pop");

endmodule

// ===== sv/m3i_front.sv =====
// Front pipeline: cofactors, determinant, rounding and singular classification.
module m3i_front #(
  parameter int W = m3i_pkg::DATA_WIDTH_DEF,
  parameter int F = m3i_pkg::FRAC_BITS_DEF,
  localparam int CW = 2 * W + 1,
  localparam int DTW = 3 * W + 3,
  localparam int MIDW = 2 + W + DTW + 9 * CW
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_push,
  input  logic [9*W-1:0]  in_data,
  input  logic [W-2:0]    thr,
  input  logic            mid_full,
  output logic            mid_push,
  output logic [MIDW-1:0] mid_data
);

  localparam int CMPW = DTW + 2 * F;
  localparam logic [DTW-1:0] HALF = DTW'(1) << (2 * F - 1);
  localparam logic [W-1:0] LIM_POS = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] LIM_NEG = {1'b1, {(W - 1){1'b0}}};

  logic                  fe;
  logic [8:1]            v;
  logic signed [W-1:0]   a1 [9];
  logic signed [2*W-1:0] p2 [18];
  logic signed [W-1:0]   t2 [3];
  logic signed [W-1:0]   t3 [3];
  logic signed [CW-1:0]  c3 [9];
  logic signed [CW-1:0]  c4 [9];
  logic signed [CW-1:0]  c5 [9];
  logic signed [CW-1:0]  c6 [9];
  logic signed [CW-1:0]  c7 [9];
  logic signed [CW-1:0]  c8 [9];
  logic signed [2*W:0]   pl4 [3];
  logic signed [2*W:0]   ph4 [3];
  logic signed [DTW-1:0] d5 [3];
  logic signed [DTW-1:0] det6;
  logic [DTW-1:0]        mag7;
  logic                  neg7;
  logic [DTW-1:0]        mag8;
  logic                  neg8;
  logic [W-1:0]          dv8;
  logic                  sing8;
  logic [DTW-1:0]        rnd;
  logic [W-1:0]          lim;
  logic [W-1:0]          rmag;
  logic [9*CW-1:0]       cpack;

  assign fe = !mid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (fe) begin
      v <= {v[7:1], in_push};
    end
  end

  always_comb begin
    rnd  = (mag7 + HALF) >> (2 * F);
    lim  = neg7 ? LIM_NEG : LIM_POS;
    rmag = (rnd > DTW'(lim)) ? lim : rnd[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      for (int i = 0; i < 9; i++) begin
        a1[i]      <= in_data[i*W +: W];
        p2[2*i]    <= a1[m3i_pkg::COF_IDX[i][0]] * a1[m3i_pkg::COF_IDX[i][1]];
        p2[2*i+1]  <= a1[m3i_pkg::COF_IDX[i][2]] * a1[m3i_pkg::COF_IDX[i][3]];
        c3[i]      <= CW'(p2[2*i]) - CW'(p2[2*i+1]);
        c4[i]      <= c3[i];
        c5[i]      <= c4[i];
        c6[i]      <= c5[i];
        c7[i]      <= c6[i];
        c8[i]      <= c7[i];
      end
      for (int j = 0; j < 3; j++) begin
        t2[j]  <= a1[j];
        t3[j]  <= t2[j];
        pl4[j] <= t3[j] * $signed({1'b0, c3[3*j][W-1:0]});
        ph4[j] <= t3[j] * $signed(c3[3*j][CW-1:W]);
        d5[j]  <= (DTW'(ph4[j]) <<< W) + DTW'(pl4[j]);
      end
      det6  <= d5[0] + d5[1] + d5[2];
      neg7  <= det6[DTW-1];
      mag7  <= det6[DTW-1] ? DTW'(-det6) : DTW'(det6);
      neg8  <= neg7;
      mag8  <= mag7;
      dv8   <= neg7 ? W'(-rmag) : rmag;
      sing8 <= CMPW'(mag7) <= (CMPW'(thr) << (2 * F));
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      cpack[i*CW +: CW] = c8[i];
    end
  end

  assign mid_push = fe && v[8];
  assign mid_data = {sing8, neg8, dv8, mag8, cpack};

endmodule

// ===== sv/m3i_back.sv =====
// Back pipeline: nine restoring dividers, saturation and identity select.
module m3i_back #(
  parameter int W = m3i_pkg::DATA_WIDTH_DEF,
  parameter int F = m3i_pkg::FRAC_BITS_DEF,
  localparam int CW = 2 * W + 1,
  localparam int DTW = 3 * W + 3,
  localparam int MIDW = 2 + W + DTW + 9 * CW,
  localparam int OUTW = 1 + W + 9 * W
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            mid_empty,
  input  logic [MIDW-1:0] mid_data,
  output logic            mid_pop,
  input  logic            out_full,
  output logic            out_push,
  output logic [OUTW-1:0] out_data
);

  localparam int RW = 4 * W + 2 * F + 4;
  localparam logic [W-1:0] LIM_POS = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] LIM_NEG = {1'b1, {(W - 1){1'b0}}};
  localparam logic [W-1:0] ONE = (F < W - 1) ? (W'(1) << F) : LIM_POS;

  logic                 be;
  logic [W+2:0]         vb;
  logic signed [CW-1:0] mc [9];
  logic [DTW-1:0]       mmag;
  logic [W-1:0]         mdv;
  logic                 mneg;
  logic                 msing;

  logic [CW-1:0]        cm1 [9];
  logic [8:0]           cn1;
  logic [DTW-1:0]       mag1;
  logic [W-1:0]         dv1;
  logic                 sing1;

  logic [RW-1:0]        num2 [9];
  logic [RW-1:0]        den2;
  logic [8:0]           cn2;
  logic [W-1:0]         dv2;
  logic                 sing2;

  logic [RW-1:0]        r   [W+1][9];
  logic [W-1:0]         q   [W+1][9];
  logic [8:0]           ovd [W+1];
  logic [8:0]           cnd [W+1];
  logic [RW-1:0]        dend [W+1];
  logic [W-1:0]         dvd [W+1];
  logic [W:0]           singd;

  logic [W-1:0]         b [9];
  logic [W-1:0]         lim;
  logic [W-1:0]         mag;

  assign be       = !out_full;
  assign mid_pop  = be && !mid_empty;
  assign out_push = be && vb[W+2];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      mc[i] = mid_data[i*CW +: CW];
    end
    mmag  = mid_data[9*CW +: DTW];
    mdv   = mid_data[9*CW+DTW +: W];
    mneg  = mid_data[9*CW+DTW+W];
    msing = mid_data[MIDW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= '0;
    end else if (be) begin
      vb <= {vb[W+1:0], !mid_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      for (int i = 0; i < 9; i++) begin
        cm1[i] <= mc[i][CW-1] ? CW'(-mc[i]) : CW'(mc[i]);
        cn1[i] <= mc[i][CW-1] ^ mneg;
        num2[i] <= (RW'(cm1[i]) << (2 * F + 1)) + RW'(mag1);
        r[0][i] <= num2[i];
        q[0][i] <= '0;
        ovd[0][i] <= num2[i] >= (den2 << W);
      end
      mag1  <= mmag;
      dv1   <= mdv;
      sing1 <= msing;
      den2  <= RW'(mag1) << 1;
      cn2   <= cn1;
      dv2   <= dv1;
      sing2 <= sing1;
      dend[0]  <= den2;
      cnd[0]   <= cn2;
      dvd[0]   <= dv2;
      singd[0] <= sing2;
      for (int s = 1; s <= W; s++) begin
        for (int i = 0; i < 9; i++) begin
          if (r[s-1][i] >= (dend[s-1] << (W - s))) begin
            r[s][i] <= r[s-1][i] - (dend[s-1] << (W - s));
            q[s][i] <= q[s-1][i] | (W'(1) << (W - s));
          end else begin
            r[s][i] <= r[s-1][i];
            q[s][i] <= q[s-1][i];
          end
        end
        ovd[s]   <= ovd[s-1];
        cnd[s]   <= cnd[s-1];
        dend[s]  <= dend[s-1];
        dvd[s]   <= dvd[s-1];
        singd[s] <= singd[s-1];
      end
    end
  end

  always_comb begin
    lim = LIM_POS;
    mag = '0;
    for (int i = 0; i < 9; i++) begin
      lim = cnd[W][i] ? LIM_NEG : LIM_POS;
      mag = (ovd[W][i] || q[W][i] > lim) ? lim : q[W][i];
      if (singd[W]) begin
        b[i] = (i % 4 == 0) ? ONE : '0;
      end else begin
        b[i] = cnd[W][i] ? W'(-mag) : mag;
      end
      out_data[i*W +: W] = b[i];
    end
    out_data[9*W +: W] = dvd[W];
    out_data[OUTW-1]   = singd[W];
  end

endmodule

// ===== tb/mat3_inverse_adjugate_tb.sv =====
// Self-checking testbench for the 3x3 adjugate matrix inverse.
module mat3_inverse_adjugate_tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [31:0] ent_t;
  typedef logic signed [127:0] wide_t;

  typedef struct {
    ent_t b[9];
    ent_t det;
    logic sing;
  } inv_t;

  localparam ent_t ONE = 32'sd65536;
  localparam ent_t EMAX = 32'sh7FFFFFFF;
  localparam ent_t EMIN = 32'sh80000000;

  class inverse_board;
    inv_t inv_q[$];
    logic [30:0] thr;
    int errors;

    function new();
      thr = 31'd1;
      errors = 0;
    endfunction

    function ent_t clamp(logic [127:0] mag, bit neg);
      logic [127:0] lim;
      ent_t v;
      lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (mag > lim) mag = lim;
      v = mag[31:0];
      if (neg) v = -v;
      return v;
    endfunction

    function void note_matrix(ent_t a[9]);
      wide_t s[9];
      wide_t c[9];
      wide_t det;
      logic [127:0] dm, cm, num;
      bit dneg, cneg;
      inv_t r;
      for (int i = 0; i < 9; i++) s[i] = a[i];
      for (int i = 0; i < 9; i++)
        c[i] = s[m3i_pkg::COF_IDX[i][0]] * s[m3i_pkg::COF_IDX[i][1]]
             - s[m3i_pkg::COF_IDX[i][2]] * s[m3i_pkg::COF_IDX[i][3]];
      det = s[0] * c[0] + s[1] * c[3] + s[2] * c[6];
      dneg = det < 0;
      dm = dneg ? -det : det;
      r.det = clamp((dm + (128'd1 << 31)) >> 32, dneg);
      r.sing = dm <= ({97'd0, thr} << 32);
      for (int i = 0; i < 9; i++) begin
        if (r.sing) begin
          r.b[i] = (i % 4 == 0) ? ONE : 32'sd0;
        end else begin
          cneg = c[i] < 0;
          cm = cneg ? -c[i] : c[i];
          num = (cm << 32) << 1;
          r.b[i] = clamp((num + dm) / (dm << 1), cneg ^ dneg);
        end
      end
      inv_q.push_back(r);
    endfunction

    function void check_result(inv_t act);
      inv_t e;
      if (inv_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      e = inv_q.pop_front();
      for (int i = 0; i < 9; i++)
        if (act.b[i] !== e.b[i]) begin
          $error("b%0d%0d: expected %0d, got %0d", i / 3, i % 3, e.b[i], act.b[i]);
          errors++;
        end
      if (act.det !== e.det) begin
        $error("det_value: expected %0d, got %0d", e.det, act.det);
        errors++;
      end
      if (act.sing !== e.sing) begin
        $error("singular: expected %0b, got %0b", e.sing, act.sing);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  ent_t a[9];
  ent_t b[9];
  ent_t det_value;
  logic singular;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  bit calm = 1'b0;

  inverse_board board = new();

  initial for (int i = 0; i < 9; i++) a[i] = '0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  mat3_inverse_adjugate DUT (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .a00(a[0]), .a01(a[1]), .a02(a[2]), .a10(a[3]), .a11(a[4]), .a12(a[5]),
    .a20(a[6]), .a21(a[7]), .a22(a[8]),
    .empty(empty), .pop(pop),
    .b00(b[0]), .b01(b[1]), .b02(b[2]), .b10(b[3]), .b11(b[4]), .b12(b[5]),
    .b20(b[6]), .b21(b[7]), .b22(b[8]),
    .det_value(det_value), .singular(singular),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always @(posedge clk) begin
    inv_t act;
    if (!rst && push && !full) board.note_matrix(a);
    if (!rst && pop && !empty) begin
      act.b = b;
      act.det = det_value;
      act.sing = singular;
      board.check_result(act);
    end
  end

  always @(negedge clk) begin
    pop <= !rst && (calm || $urandom_range(99) >= 9);
  end

  task automatic send_matrix(input ent_t m[9]);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 9) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    a = m;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    push = 1'b0;
    while (board.inv_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [31:0] v);
    logic [31:0] rd;
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = 3'(m3i_pkg::REG_THRESHOLD * 4); pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.thr = v[30:0];
    @(negedge clk);
    penable = 1'b0; pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
    if (rd !== {1'b0, v[30:0]}) begin
      $error("singular_threshold readback: expected %0h, got %0h", {1'b0, v[30:0]}, rd);
      board.errors++;
    end
  endtask

  function automatic void diag(output ent_t m[9], input ent_t x, ent_t y, ent_t z);
    for (int i = 0; i < 9; i++) m[i] = 32'sd0;
    m[0] = x; m[4] = y; m[8] = z;
  endfunction

  function automatic ent_t small_ent();
    return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
  endfunction

  task automatic run_directed();
    ent_t m[9];
    diag(m, ONE, ONE, ONE); send_matrix(m);
    diag(m, 0, 0, 0); send_matrix(m);
    for (int i = 0; i < 9; i++) m[i] = EMAX;
    send_matrix(m);
    for (int i = 0; i < 9; i++) m[i] = EMIN;
    send_matrix(m);
    diag(m, EMAX, EMAX, EMAX); send_matrix(m);
    diag(m, EMIN, EMIN, EMIN); send_matrix(m);
    diag(m, EMIN, EMAX, EMIN); send_matrix(m);
    diag(m, ONE, 2 * ONE, 4 * ONE); send_matrix(m);
    diag(m, -ONE, 3 * ONE, -5 * ONE); send_matrix(m);
    diag(m, 1, 1, 1); send_matrix(m);
    diag(m, ONE, ONE, 1); send_matrix(m);
    diag(m, ONE, ONE, 2); send_matrix(m);
    diag(m, -ONE, ONE, 2); send_matrix(m);
    diag(m, ONE, ONE, -ONE); send_matrix(m);
    m = '{2 * ONE, ONE, 0, ONE, 3 * ONE, ONE, 0, ONE, 4 * ONE}; send_matrix(m);
    m = '{ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 7, -9, ONE}; send_matrix(m);
    m = '{0, ONE, 0, 0, 0, ONE, ONE, 0, 0}; send_matrix(m);
    m = '{0, 0, -ONE, 0, ONE, 0, ONE, 0, 0}; send_matrix(m);
    m = '{3, -7, 11, 5, 2, -1, 9, 4, 6}; send_matrix(m);
    m = '{EMAX, EMIN, 0, 0, EMAX, EMIN, EMIN, 0, EMAX}; send_matrix(m);
  endtask

  task automatic run_random(input int count);
    ent_t m[9];
    int kind;
    int sh;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) m[i] = small_ent();
      case (kind)
        0, 1: begin
          for (int i = 0; i < 9; i++) m[i] = $urandom;
        end
        6, 7: begin
          for (int i = 0; i < 3; i++)
            m[6 + i] = m[i] + m[3 + i] + $signed($urandom_range(0, 30)) - 15;
        end
        8: begin
          diag(m, small_ent(), small_ent(), $signed($urandom_range(0, 64)) - 32);
        end
        9: begin
          for (int i = 0; i < 9; i++) begin
            sh = $urandom_range(0, 13);
            m[i] = m[i] <<< sh;
          end
        end
        default: ;
      endcase
      send_matrix(m);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    repeat (2) @(posedge clk);

    run_directed();
    run_random(300);
    drain();

    write_threshold(32'd0);
    run_directed();
    calm = 1'b1;
    run_random(150);
    calm = 1'b0;
    run_random(100);
    drain();

    write_threshold(32'hFFFF_FFFF);
    run_random(200);
    drain();

    write_threshold($urandom);
    run_random(200);
    drain();

    write_threshold(32'd65536);
    run_random(200);
    drain();

    if (board.errors == 0 && board.inv_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
